// File: rtl/core/tet_pkg.sv
package tet_pkg;

    // Fixed field widths
    localparam int KEY_W  = 64;
    localparam int TIME_W = 31;
    localparam int EXP_W  = 32;

    // Operation codes on the op field
    localparam logic [1:0] OP_GENERATE = 2'd0;
    localparam logic [1:0] OP_RENEW    = 2'd1;
    localparam logic [1:0] OP_COUNT    = 2'd2;

    // Number of commands held between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Classified operation
    typedef enum logic [1:0] {
        KIND_GENERATE,
        KIND_RENEW,
        KIND_COUNT,
        KIND_NONE
    } op_kind_t;

    // Command handed from the front to the back
    typedef struct packed {
        op_kind_t                kind;
        logic [KEY_W-1:0]        key;
        logic [TIME_W-1:0]       now;
        logic [EXP_W-1:0]        expiry;
        logic                    ttl_nonzero;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } back_state_t;

endpackage

// File: rtl/core/tet_front.sv
module tet_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tet_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    input  logic [1:0]                    op,
    input  logic [tet_pkg::KEY_W-1:0]     token_key,
    input  logic [tet_pkg::TIME_W-1:0]    now,
    input  logic                          queue_full,
    output logic                          in_stall,
    output logic                          push,
    output tet_pkg::cmd_t                 cmd
);
    import tet_pkg::*;

    logic [TIME_W-1:0] time_to_live_reg;
    op_kind_t          kind;

    // Lifetime register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_to_live_reg <= TIME_W'(60);
        end
        else if (cfg_wr_en)
        begin
            time_to_live_reg <= cfg_wr_data;
        end
    end

    // Classify the operation
    always_comb
    begin
        unique case (op)
            OP_GENERATE: kind = KIND_GENERATE;
            OP_RENEW:    kind = KIND_RENEW;
            OP_COUNT:    kind = KIND_COUNT;
            default:     kind = KIND_NONE;
        endcase
    end

    // Build the command; new expiry worked out once here
    always_comb
    begin
        cmd.kind        = kind;
        cmd.key         = token_key;
        cmd.now         = now;
        cmd.expiry      = {1'b0, now} + {1'b0, time_to_live_reg};
        cmd.ttl_nonzero = (time_to_live_reg != '0);
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// File: rtl/core/tet_queue.sv
module tet_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tet_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output logic            empty,
    output logic            full,
    output tet_pkg::cmd_t   head
);
    import tet_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/tet_back.sv
module tet_back #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              queue_empty,
    input  tet_pkg::cmd_t                     head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [$clog2(DEPTH+1)-1:0]        live_count,
    output logic                              success
);
    import tet_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 done_reg;
    logic [DEPTH-1:0]     slot_valid_reg;
    logic                 out_valid_reg;
    logic [CNT_W-1:0]     live_count_reg;
    logic                 success_reg;

    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [EXP_W-1:0]     exp_mem [DEPTH];
    logic [KEY_W-1:0]     rd_key_reg;
    logic [EXP_W-1:0]     rd_exp_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic                 scan_en;
    logic                 load_out;
    logic                 out_free;
    logic                 last;
    logic                 live;
    logic                 hit;
    logic                 live_after;
    logic                 ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign last     = (idx_reg == IDX_W'(DEPTH-1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!queue_empty) state_next = S_SCAN;
            S_SCAN:  if (last)         state_next = S_DONE;
            S_DONE:  if (out_free)     state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        scan_en  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:  pop      = !queue_empty;
            S_SCAN:  scan_en  = 1'b1;
            S_DONE:  load_out = out_free;
            default: pop      = 1'b0;
        endcase
    end

    // Read address runs one slot ahead of the slot being examined
    always_comb
    begin
        if (state_reg == S_SCAN && !last)
        begin
            rd_addr = idx_reg + 1'b1;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Examine one slot: free if expired, then generate or renew
    always_comb
    begin
        live = slot_valid_reg[idx_reg] && (rd_exp_reg > {1'b0, cmd_reg.now});
        hit  = 1'b0;
        if (!done_reg)
        begin
            case (cmd_reg.kind)
                KIND_GENERATE: hit = !live;
                KIND_RENEW:    hit = live && (rd_key_reg == cmd_reg.key);
                default:       hit = 1'b0;
            endcase
        end
        live_after = hit ? cmd_reg.ttl_nonzero : live;
    end

    // Final success flag
    always_comb
    begin
        case (cmd_reg.kind)
            KIND_GENERATE: ok = done_reg;
            KIND_RENEW:    ok = done_reg;
            KIND_COUNT:    ok = 1'b1;
            default:       ok = 1'b0;
        endcase
    end

    // Key and expiry store, registered read
    always_ff @(posedge clk)
    begin
        if (scan_en && hit)
        begin
            key_mem[idx_reg] <= cmd_reg.key;
            exp_mem[idx_reg] <= cmd_reg.expiry;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_exp_reg <= exp_mem[rd_addr];
    end

    // Command held during the scan
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            live_count_reg <= count_reg;
            success_reg    <= ok;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                idx_reg   <= '0;
                count_reg <= '0;
                done_reg  <= 1'b0;
            end
            else if (scan_en)
            begin
                slot_valid_reg[idx_reg] <= hit || live;
                count_reg <= count_reg + CNT_W'(live_after);
                done_reg  <= done_reg || hit;
                if (!last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign live_count = live_count_reg;
    assign success    = success_reg;

endmodule

// File: rtl/core/token_expiry_table.sv
// Channel   Handshake             Payload
// cfg       cfg_wr_en             cfg_wr_data (time_to_live, 31 bits)
// in        in_valid / in_stall   op, token_key, now
// out       out_valid / out_stall live_count, success
//
// Each item passes through the back end in order: it is taken from the queue, then
// the slots of the key and expiry store are examined one per cycle through its
// single read port, and then the result is loaded.
// A two-entry queue lets the front take items while the back is scanning.
// Reset empties the table and sets time_to_live to 60; no clearing pass.
// A result waiting under out_stall holds the back end, the queue keeps filling.
module token_expiry_table #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tet_pkg::TIME_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [tet_pkg::KEY_W-1:0]         token_key,
    input  logic [tet_pkg::TIME_W-1:0]        now,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [$clog2(DEPTH+1)-1:0]        live_count,
    output logic                              success
);
    import tet_pkg::*;

    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    cmd_t  push_cmd;
    cmd_t  head;

    tet_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .op          (op),
        .token_key   (token_key),
        .now         (now),
        .queue_full  (q_full),
        .in_stall    (in_stall),
        .push        (push),
        .cmd         (push_cmd)
    );

    tet_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .empty    (q_empty),
        .full     (q_full),
        .head     (head)
    );

    tet_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .live_count  (live_count),
        .success     (success)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tet_pkg::*;

    localparam int          DEPTH        = 16;
    localparam int          COUNT_W      = $clog2(DEPTH + 1);
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [30:0] TIME_MAX     = 31'h7FFF_FFFF;
    localparam logic [30:0] TTL_RESET    = 31'd60;
    localparam int          GAP_MAX      = 19;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          PRINT_MAX    = 50;
    localparam int          POOL_SIZE    = 6;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } token_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] live;
        logic               ok;
    } token_result_t;

    // Block ports
    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TIME_W-1:0]    cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           op          = '0;
    logic [KEY_W-1:0]     token_key   = '0;
    logic [TIME_W-1:0]    now         = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [COUNT_W-1:0]   live_count;
    logic                 success;

    // Predicted table contents and lifetime register
    logic                 tab_valid  [DEPTH];
    logic [KEY_W-1:0]     tab_key    [DEPTH];
    logic [EXP_W-1:0]     tab_expiry [DEPTH];
    logic [TIME_W-1:0]    ttl_model = TTL_RESET;

    token_item_t          pending_items [$];
    token_result_t        expected_results [$];
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];
    logic [TIME_W-1:0]    clock_now = '0;

    int                   mismatch_count = 0;
    int                   result_index   = 0;
    int                   in_gap         = 0;
    int                   out_hold       = 0;
    bit                   in_calm        = 1'b0;
    bit                   out_calm       = 1'b0;

    token_expiry_table #(
        .DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .token_key   (token_key),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .live_count  (live_count),
        .success     (success)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tab_valid[i]  = 1'b0;
            tab_key[i]    = '0;
            tab_expiry[i] = '0;
        end
    end

    // Free expired slots, apply one item to the predicted table, return its result
    function automatic token_result_t apply_token_op(input logic [1:0] code,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [TIME_W-1:0] t);
        token_result_t      r;
        logic [EXP_W-1:0]   t_ext;
        logic [EXP_W-1:0]   new_expiry;
        int                 live;
        bit                 done;
        t_ext      = {1'b0, t};
        new_expiry = t_ext + {1'b0, ttl_model};
        done       = 1'b0;
        live       = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tab_valid[i] && tab_expiry[i] <= t_ext)
                tab_valid[i] = 1'b0;
        case (code)
            OP_GENERATE:
                for (int i = 0; i < DEPTH; i++)
                    if (!done && !tab_valid[i])
                    begin
                        tab_valid[i]  = 1'b1;
                        tab_key[i]    = key;
                        tab_expiry[i] = new_expiry;
                        done          = 1'b1;
                    end
            OP_RENEW:
                for (int i = 0; i < DEPTH; i++)
                    if (!done && tab_valid[i] && tab_key[i] == key && tab_expiry[i] > t_ext)
                    begin
                        tab_expiry[i] = new_expiry;
                        done          = 1'b1;
                    end
            OP_COUNT:
                done = 1'b1;
            default:
                done = 1'b0;
        endcase
        for (int i = 0; i < DEPTH; i++)
            if (tab_valid[i] && tab_expiry[i] > t_ext)
                live++;
        r.live = live[COUNT_W-1:0];
        r.ok   = done;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_MAX)
            $display("%0t ns: result %0d: %s", $time, result_index, what);
        mismatch_count++;
    endtask

    task automatic push_item(input logic [1:0] code, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] t);
        token_item_t it;
        it.op  = code;
        it.key = key;
        it.now = t;
        pending_items.push_back(it);
    endtask

    // Mostly keys from a small pool so renews hit; time creeps forward
    task automatic queue_random(input int count, input int step_cap);
        token_item_t it;
        int          pick;
        int          step_max;
        int          step;
        for (int k = 0; k < POOL_SIZE; k++)
            key_pool[k] = {$urandom, $urandom};
        step_max = ttl_model / (4 << (2 * $urandom_range(0, 2)));
        if (step_max > step_cap)
            step_max = step_cap;
        if (step_max < 2)
            step_max = 2;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                it.op = OP_GENERATE;
            else if (pick < 80)
                it.op = OP_RENEW;
            else if (pick < 95)
                it.op = OP_COUNT;
            else
                it.op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0)
                it.key = {$urandom, $urandom};
            else
                it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            step = $urandom_range(0, step_max);
            if (clock_now > TIME_MAX - TIME_W'(step))
                clock_now = TIME_W'(step);
            else
                clock_now = clock_now + TIME_W'(step);
            // occasional small step back in time
            if ($urandom_range(0, 29) == 0 && clock_now > 20)
                it.now = clock_now - TIME_W'($urandom_range(1, 20));
            else
                it.now = clock_now;
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ttl(input logic [TIME_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ttl_model    = value;
    endtask

    // Input driver: one item per handshake, random gap after each outside calm spells
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        token_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_token_op(op, token_key, now));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt        = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    op        <= nxt.op;
                    token_key <= nxt.key;
                    now       <= nxt.now;
                    in_gap    <= in_calm ? 0 : $urandom_range(0, GAP_MAX);
                    if ($urandom_range(0, 40) == 0)
                        in_calm <= !in_calm;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each result, then stall the next one a while
    always @(posedge clk or negedge rst_n)
    begin : check_results
        token_result_t want;
        int            hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result live_count %0d success %0b",
                                              live_count, success));
                else
                begin
                    want = expected_results.pop_front();
                    if (live_count !== want.live)
                        report_mismatch($sformatf("live_count %0d, expected %0d",
                                                  live_count, want.live));
                    if (success !== want.ok)
                        report_mismatch($sformatf("success %0b, expected %0b",
                                                  success, want.ok));
                end
                result_index++;
                hold = out_calm ? 0 : $urandom_range(0, GAP_MAX);
                out_hold  <= hold;
                out_stall <= (hold != 0);
                if ($urandom_range(0, 40) == 0)
                    out_calm <= !out_calm;
            end
            else if (out_valid && out_hold > 0)
            begin
                out_hold  <= out_hold - 1;
                out_stall <= (out_hold > 1);
            end
        end
    end

    // Stimulus phases
    initial
    begin : stimulus
        logic [KEY_W-1:0] edge_key;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, unused op, key extremes, renew hit and miss
        push_item(OP_COUNT, '0, 31'd0);
        push_item(OP_UNUSED, '1, 31'd0);
        push_item(OP_GENERATE, '0, 31'd0);
        push_item(OP_GENERATE, '1, 31'd0);
        push_item(OP_RENEW, '0, 31'd10);
        push_item(OP_RENEW, 64'd1, 31'd10);
        // expiry at or before now frees both entries
        push_item(OP_COUNT, '0, 31'd70);
        // fill the table, then one generate too many
        for (int i = 0; i < DEPTH; i++)
            push_item(OP_GENERATE, {$urandom, $urandom}, 31'd100);
        push_item(OP_GENERATE, 64'h5A5A_5A5A_A5A5_A5A5, 31'd100);
        // time going backwards
        push_item(OP_COUNT, '0, 31'd40);
        clock_now = 31'd100;
        queue_random(250, 1 << 20);

        write_ttl(31'd1);
        queue_random(250, 1 << 20);

        // zero lifetime: stored entries are dead on arrival
        write_ttl(31'd0);
        queue_random(200, 1 << 20);

        write_ttl(TIME_W'($urandom_range(2, 100000)));
        queue_random(250, 1 << 20);

        write_ttl(31'd7);
        queue_random(220, 1 << 20);

        // longest lifetime and latest time: nothing expires from here on
        write_ttl(TIME_MAX);
        edge_key = {$urandom, $urandom};
        push_item(OP_GENERATE, edge_key, TIME_MAX);
        push_item(OP_RENEW, edge_key, TIME_MAX);
        push_item(OP_COUNT, '0, TIME_MAX);
        clock_now = 31'h7F00_0000;
        queue_random(200, 1 << 20);

        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
